@@ rtl/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

@@ rtl/pfrle_pkg.sv @@
`default_nettype none
package pfrle_pkg;
   localparam int PaletteDepthDef = 256;
   localparam int MaxRunDef = 255;

   localparam logic [3:0] FMT_INDEX1 = 4'd0;
   localparam logic [3:0] FMT_INDEX2 = 4'd1;
   localparam logic [3:0] FMT_INDEX4 = 4'd2;
   localparam logic [3:0] FMT_INDEX8 = 4'd3;
   localparam logic [3:0] FMT_RGB565 = 4'd4;
   localparam logic [3:0] FMT_RGB555 = 4'd5;
   localparam logic [3:0] FMT_RGB444 = 4'd6;
   localparam logic [3:0] FMT_RGB332 = 4'd7;
   localparam logic [3:0] FMT_RGB888 = 4'd8;
   localparam logic [3:0] FMT_RGBA = 4'd9;
   localparam logic [3:0] FMT_CUSTOM = 4'd10;

   localparam logic [2:0] REG_FORMAT = 3'd0;
   localparam logic [2:0] REG_ENC = 3'd1;
   localparam logic [2:0] REG_DEPTH = 3'd2;
   localparam logic [2:0] REG_COUNT = 3'd3;
   localparam logic [2:0] REG_MRED = 3'd4;
   localparam logic [2:0] REG_MGRN = 3'd5;
   localparam logic [2:0] REG_MBLU = 3'd6;
   localparam logic [2:0] REG_MALP = 3'd7;

   typedef struct packed {
      logic       mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] palette_index;
      logic       last_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_WAIT, ST_CONV, ST_EMIT
   } state_type;

   function automatic logic [5:0] depth_bits(input logic [2:0] code);
      case (code)
         3'd0: depth_bits = 6'd1;
         3'd1: depth_bits = 6'd2;
         3'd2: depth_bits = 6'd4;
         3'd3: depth_bits = 6'd8;
         3'd4: depth_bits = 6'd16;
         3'd5: depth_bits = 6'd24;
         default: depth_bits = 6'd32;
      endcase
   endfunction

   function automatic logic [4:0] tz(input logic [31:0] m);
      logic [4:0] s;
      s = 5'd31;
      for (int i = 31; i >= 0; i--) begin
         if (m[i]) s = 5'(i);
      end
      tz = s;
   endfunction

   function automatic logic [31:0] place(input logic [7:0] c, input logic [31:0] m);
      place = ({24'd0, c} << tz(m)) & m;
   endfunction

   function automatic logic [8:0] adiff(input logic [7:0] a, input logic [7:0] b);
      adiff = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
   endfunction
endpackage
`default_nettype wire

@@ rtl/pfrle_ram.sv @@
`default_nettype none
module pfrle_ram #(
   parameter int Width = 24,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ rtl/pixel_format_rle_packer.sv @@
// pixel format converter with raw bit packing or run-length encoding
// req_*: one transaction per pixel (mode 0) or palette write (mode 1).
// rsp_*: the output bytes of each pixel, frame_end on the last byte of a frame.
// csr_*: register writes, taken only while the block is idle.
// a pixel gives up to 10 output bytes, built together into an emit buffer;
// raw rgba8888 at 32 bits gives four bytes per pixel over the byte-wide output.
// the pixel is registered, built in ST_CONV and its first byte offered from the output register in ST_EMIT.
// index formats first search the palette entries (palette_count,
// capped at the palette depth), one palette memory read per entry
// through a single read port.
// palette writes give no byte.
// the output register holds its byte while rsp_ready is low; the block
// then waits before taking the next byte out of its emit buffer.
// reset returns registers to rgba8888, raw, 32 bits, and discards any open run
// or partial byte; palette contents are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module pixel_format_rle_packer
   import pfrle_pkg::*;
#(
   parameter int PALETTE_DEPTH = PaletteDepthDef,
   parameter int MAX_RUN = MaxRunDef
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [3:0] fmt_ff;
   logic enc_ff;
   logic [2:0] dep_ff;
   logic [8:0] cnt_ff;
   logic [31:0] mr_ff, mg_ff, mb_ff, ma_ff;

   state_type st_ff, st_in;
   req_type px_ff;
   logic [8:0] idx_ff;
   logic [9:0] bestd_ff;
   logic [7:0] best_ff;
   logic [31:0] rv_ff;
   logic [7:0] rl_ff;
   logic [7:0] acc_ff;
   logic [2:0] bf_ff;
   logic [7:0] buf_ff [10];
   logic [3:0] n_ff, ptr_ff;
   logic ov_ff;
   logic [8:0] ob_ff;

   logic [23:0] pal_rd;
   logic pal_we;
   logic [AW-1:0] raddr;

   assign req_ready = (st_ff == ST_IDLE);
   assign csr_ready = (st_ff == ST_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data = rsp_type'(ob_ff);
   assign pal_we = req_valid && req_ready && req_data.mode &&
                   ({1'b0, req_data.palette_index} < 9'(PALETTE_DEPTH));
   // entry 0 is read before the search, entry idx+1 while idx is compared
   assign raddr = (st_ff == ST_WAIT) ? idx_ff[AW-1:0] + AW'(1) : '0;

   pfrle_ram #(.Width(24), .Depth(PALETTE_DEPTH)) u_pal (
      .clock, .we(pal_we), .waddr(req_data.palette_index[AW-1:0]),
      .wdata({req_data.red, req_data.green, req_data.blue}),
      .raddr, .rdata(pal_rd)
   );

   logic [8:0] lim;
   assign lim = (cnt_ff > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : cnt_ff;
   logic [9:0] pal_dist;
   assign pal_dist = {1'b0, adiff(px_ff.red, pal_rd[23:16])} +
                     {1'b0, adiff(px_ff.green, pal_rd[15:8])} +
                     {1'b0, adiff(px_ff.blue, pal_rd[7:0])};

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_RGBA; enc_ff <= 1'b0; dep_ff <= 3'd6; cnt_ff <= '0;
         mr_ff <= '0; mg_ff <= '0; mb_ff <= '0; ma_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FORMAT: fmt_ff <= csr_data[3:0];
            REG_ENC:    enc_ff <= csr_data[0];
            REG_DEPTH:  dep_ff <= csr_data[2:0];
            REG_COUNT:  cnt_ff <= csr_data[8:0];
            REG_MRED:   mr_ff <= csr_data;
            REG_MGRN:   mg_ff <= csr_data;
            REG_MBLU:   mb_ff <= csr_data;
            REG_MALP:   ma_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // conversion and byte building, done in one step into the emit buffer
   logic [31:0] v;
   logic [7:0] b_in [10];
   logic [3:0] n_in;
   logic [7:0] acc_in, rl_in;
   logic [2:0] bf_in;
   logic [31:0] rv_in;
   logic [5:0] bits;

   always_comb begin
      logic [7:0] r, g, b, a;
      logic [3:0] bc;
      logic [3:0] f;
      r = px_ff.red; g = px_ff.green; b = px_ff.blue; a = px_ff.alpha;
      bits = depth_bits(dep_ff);
      f = fmt_ff;
      case (f) inside
         [FMT_INDEX1:FMT_INDEX8]: v = {24'd0, best_ff};
         FMT_RGB565: v = {16'd0, r[7:3], g[7:2], b[7:3]};
         FMT_RGB555: v = {17'd0, r[7:3], g[7:3], b[7:3]};
         FMT_RGB444: v = {20'd0, r[7:4], g[7:4], b[7:4]};
         FMT_RGB332: v = {24'd0, r[7:5], g[7:5], b[7:6]};
         FMT_RGB888: v = {8'd0, r, g, b};
         FMT_RGBA:   v = {r, g, b, a};
         FMT_CUSTOM: v = place(r, mr_ff) | place(g, mg_ff) | place(b, mb_ff) |
                         place(a, ma_ff);
         default: v = '0;
      endcase
      for (int i = 0; i < 10; i++) b_in[i] = '0;
      bc = '0;
      acc_in = acc_ff; bf_in = bf_ff; rl_in = rl_ff; rv_in = rv_ff;
      // open run goes out first whenever it closes
      if (!(enc_ff && rl_ff != 0 && v == rv_ff && rl_ff < 8'(MAX_RUN)) &&
          rl_ff != 0) begin
         b_in[bc] = rl_ff; bc = bc + 4'd1;
         if (bits <= 6'd8) begin
            b_in[bc] = rv_ff[7:0]; bc = bc + 4'd1;
         end else if (bits == 6'd16) begin
            b_in[bc] = rv_ff[7:0]; b_in[bc+4'd1] = rv_ff[15:8]; bc = bc + 4'd2;
         end else if (bits == 6'd24) begin
            b_in[bc] = rv_ff[23:16]; b_in[bc+4'd1] = rv_ff[15:8];
            b_in[bc+4'd2] = rv_ff[7:0]; bc = bc + 4'd3;
         end else begin
            b_in[bc] = rv_ff[31:24]; b_in[bc+4'd1] = rv_ff[23:16];
            b_in[bc+4'd2] = rv_ff[15:8]; b_in[bc+4'd3] = rv_ff[7:0];
            bc = bc + 4'd4;
         end
         rl_in = '0;
      end
      if (enc_ff) begin
         if (rl_ff != 0 && v == rv_ff && rl_ff < 8'(MAX_RUN)) rl_in = rl_ff + 8'd1;
         else begin rv_in = v; rl_in = 8'd1; end
         if (px_ff.last_pixel) begin
            b_in[bc] = rl_in; bc = bc + 4'd1;
            if (bits <= 6'd8) begin
               b_in[bc] = rv_in[7:0]; bc = bc + 4'd1;
            end else if (bits == 6'd16) begin
               b_in[bc] = rv_in[7:0]; b_in[bc+4'd1] = rv_in[15:8]; bc = bc + 4'd2;
            end else if (bits == 6'd24) begin
               b_in[bc] = rv_in[23:16]; b_in[bc+4'd1] = rv_in[15:8];
               b_in[bc+4'd2] = rv_in[7:0]; bc = bc + 4'd3;
            end else begin
               b_in[bc] = rv_in[31:24]; b_in[bc+4'd1] = rv_in[23:16];
               b_in[bc+4'd2] = rv_in[15:8]; b_in[bc+4'd3] = rv_in[7:0];
               bc = bc + 4'd4;
            end
            rl_in = '0; acc_in = '0; bf_in = '0;
         end
      end else if (bits < 6'd8) begin
         for (int k = 3; k >= 0; k--) begin
            if (6'(k) < bits) begin
               acc_in[3'd7 - bf_in] = v[k];
               if (bf_in == 3'd7) begin
                  b_in[bc] = acc_in; bc = bc + 4'd1; acc_in = '0; bf_in = '0;
               end else bf_in = bf_in + 3'd1;
            end
         end
         if (px_ff.last_pixel && bf_in != 0) begin
            b_in[bc] = acc_in; bc = bc + 4'd1; acc_in = '0; bf_in = '0;
         end
      end else begin
         if (bf_ff != 0) begin
            b_in[bc] = acc_ff; bc = bc + 4'd1; acc_in = '0; bf_in = '0;
         end
         if (bits == 6'd8) begin
            b_in[bc] = v[7:0]; bc = bc + 4'd1;
         end else if (bits == 6'd16) begin
            b_in[bc] = v[7:0]; b_in[bc+4'd1] = v[15:8]; bc = bc + 4'd2;
         end else if (bits == 6'd24) begin
            b_in[bc] = v[23:16]; b_in[bc+4'd1] = v[15:8];
            b_in[bc+4'd2] = v[7:0]; bc = bc + 4'd3;
         end else begin
            b_in[bc] = v[31:24]; b_in[bc+4'd1] = v[23:16];
            b_in[bc+4'd2] = v[15:8]; b_in[bc+4'd3] = v[7:0]; bc = bc + 4'd4;
         end
      end
      n_in = bc;
   end

   logic emit_take;
   assign emit_take = (st_ff == ST_EMIT) && (!ov_ff || rsp_ready) && (ptr_ff < n_ff);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:
            if (req_valid && !req_data.mode)
               st_in = (fmt_ff < FMT_RGB565 && cnt_ff != 0) ? ST_SEARCH : ST_CONV;
         ST_SEARCH: st_in = ST_WAIT;
         ST_WAIT: if (idx_ff + 9'd1 >= lim) st_in = ST_CONV;
         ST_CONV: st_in = ST_EMIT;
         ST_EMIT: if (ptr_ff >= n_ff && (!ov_ff || rsp_ready)) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rl_ff <= '0; rv_ff <= '0; acc_ff <= '0; bf_ff <= '0;
         ov_ff <= 1'b0; n_ff <= '0; ptr_ff <= '0; idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (emit_take) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               px_ff <= req_data;
               idx_ff <= '0;
               bestd_ff <= 10'h3FF;
               best_ff <= '0;
            end
            ST_SEARCH: ;
            ST_WAIT: begin
               // memory data for entry idx arrives here
               if (pal_dist < bestd_ff) begin
                  bestd_ff <= pal_dist; best_ff <= idx_ff[7:0];
               end
               idx_ff <= idx_ff + 9'd1;
            end
            ST_CONV: begin
               for (int i = 0; i < 10; i++) buf_ff[i] <= b_in[i];
               n_ff <= n_in; ptr_ff <= '0;
               acc_ff <= acc_in; bf_ff <= bf_in; rl_ff <= rl_in; rv_ff <= rv_in;
            end
            ST_EMIT:
               if (emit_take) begin
                  ob_ff <= {buf_ff[ptr_ff], px_ff.last_pixel && (ptr_ff + 4'd1 == n_ff)};
                  ptr_ff <= ptr_ff + 4'd1;
               end
            default: ;
         endcase
      end
   end

   `CHK_IMPL(a_no_acc_busy, clock, reset, st_ff != ST_IDLE, !req_ready)
   `CHK_IMPL(a_ptr_bound, clock, reset, 1'b1, ptr_ff <= n_ff)
   `CHK_NEXT(a_hold, clock, reset, ov_ff && !rsp_ready, ov_ff && $stable(ob_ff))
endmodule
`default_nettype wire
